// ===== hdl/lkvc_pkg.sv =====
`default_nettype none

package lkvc_pkg;

    localparam int DATA_W  = 32;
    localparam int LIMIT_W = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;
    localparam logic [DATA_W-1:0]  MISS_DATA   = 32'hFFFF_FFFF;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch the input transfer
        logic match;   // compare key against all entries, register the decision
        logic commit;  // apply the update and load the result register
    } lkvc_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/lru_key_value_cache.sv =====
// From the input transfer to m_valid the controller steps through match, then commit.
// Operations are taken one at a time, only in idle; the key compare and the age/slot
//   update are separate register stages run by the controller.
// A finished result waits in the output register while the next item is taken;
//   commit stalls while that register still holds an unaccepted result.
// Reset (aresetn low, synchronous): cache empty, all ages zero, limit 8, no result.
`default_nettype none

module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // configuration: capacity limit
    input  wire logic                      cfg_wr_en,
    input  wire logic        [LIMIT_W-1:0] cfg_wr_data,
    // request channel
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_cmd,
    input  wire logic signed [DATA_W-1:0]  s_lookup_key,
    input  wire logic signed [DATA_W-1:0]  s_write_data,
    // result channel
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_found,
    output logic signed      [DATA_W-1:0]  m_read_data,
    output logic                           m_evicted,
    output logic signed      [DATA_W-1:0]  m_evicted_key
);

    lkvc_cmd_t cmd;

    // Sequencer: idle -> match -> commit. Commit holds until the output
    // register is free or being drained by the current transfer.
    lkvc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Entry store with parallel key compare, LRU ages and result register.
    // Ages are distinct among valid entries, 0 = most recent; the entry whose
    // age equals count-1 is the eviction victim.
    lkvc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_cmd          (s_cmd),
        .in_key          (s_lookup_key),
        .in_data         (s_write_data),
        .out_found       (m_found),
        .out_read_data   (m_read_data),
        .out_evicted     (m_evicted),
        .out_evicted_key (m_evicted_key)
    );

endmodule

`default_nettype wire

// ===== hdl/lkvc_ctrl.sv =====
`default_nettype none

module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output lkvc_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    assign s_ready  = aresetn && (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign cmd.load   = s_valid && (state_reg == ST_IDLE);
    assign cmd.match  = (state_reg == ST_MATCH);
    assign cmd.commit = (state_reg == ST_COMMIT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_MATCH;
                    end
                end
                ST_MATCH: begin
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            priority if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lkvc_datapath.sv =====
`default_nettype none

module lkvc_datapath
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire lkvc_cmd_t                 cmd,
    input  wire logic                      cfg_wr_en,
    input  wire logic        [LIMIT_W-1:0] cfg_wr_data,
    input  wire logic                      in_cmd,
    input  wire logic signed [DATA_W-1:0]  in_key,
    input  wire logic signed [DATA_W-1:0]  in_data,
    output logic                           out_found,
    output logic signed      [DATA_W-1:0]  out_read_data,
    output logic                           out_evicted,
    output logic signed      [DATA_W-1:0]  out_evicted_key
);

    localparam int N  = MAX_ENTRIES;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int AW = IW;
    localparam int CW = $clog2(N + 1);

    // entry storage
    logic [DATA_W-1:0] key_reg   [N];
    logic [DATA_W-1:0] val_reg   [N];
    logic              valid_reg [N];
    logic [AW-1:0]     age_reg   [N];
    logic [CW-1:0]     count_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // latched operation
    logic              op_reg;
    logic [DATA_W-1:0] op_key_reg;
    logic [DATA_W-1:0] op_data_reg;

    // match-stage decision
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          evict_reg;
    logic [IW-1:0] lru_idx_reg;
    logic [IW-1:0] free_idx_reg;

    // result register
    logic              found_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              ev_reg;
    logic [DATA_W-1:0] evk_reg;

    logic          hit_c;
    logic [IW-1:0] hit_idx_c;
    logic [IW-1:0] lru_idx_c;
    logic          evict_c;
    logic [IW-1:0] free_idx_c;
    logic [CW-1:0] lim_eff;
    logic [CW-1:0] count_m1;
    logic          match_v [N];
    logic          lru_v   [N];
    logic          keep_v  [N];
    logic [AW-1:0] hit_age;

    // limit of zero acts as one, above the entry count acts as the entry count
    always_comb begin
        if (limit_reg == '0) begin
            lim_eff = CW'(1);
        end else if (int'(limit_reg) > N) begin
            lim_eff = CW'(N);
        end else begin
            lim_eff = CW'(limit_reg);
        end
    end

    assign count_m1 = count_reg - CW'(1);

    always_comb begin
        hit_c      = 1'b0;
        hit_idx_c  = '0;
        lru_idx_c  = '0;
        free_idx_c = '0;
        for (int i = 0; i < N; i++) begin
            match_v[i] = valid_reg[i] && (key_reg[i] == op_key_reg);
            lru_v[i]   = valid_reg[i] && (CW'(age_reg[i]) == count_m1);
        end
        evict_c = 1'b0;
        for (int i = N - 1; i >= 0; i--) begin
            if (match_v[i]) begin
                hit_c     = 1'b1;
                hit_idx_c = IW'(i);
            end
            if (lru_v[i]) begin
                lru_idx_c = IW'(i);
            end
        end
        evict_c = !hit_c && (op_reg == OP_PUT) && (count_reg >= lim_eff);
        // lowest free slot, counting the slot freed by eviction
        for (int i = N - 1; i >= 0; i--) begin
            if (!(valid_reg[i] && !(evict_c && lru_v[i]))) begin
                free_idx_c = IW'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            keep_v[i] = valid_reg[i] && !(evict_reg && (lru_idx_reg == IW'(i)));
        end
    end

    assign hit_age = age_reg[hit_idx_reg];

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                valid_reg[i] <= 1'b0;
                age_reg[i]   <= '0;
            end
            count_reg <= '0;
            limit_reg <= LIMIT_RESET;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.commit) begin
                if (hit_reg) begin
                    for (int i = 0; i < N; i++) begin
                        if (hit_idx_reg == IW'(i)) begin
                            age_reg[i] <= '0;
                        end else if (valid_reg[i] && (age_reg[i] < hit_age)) begin
                            age_reg[i] <= age_reg[i] + AW'(1);
                        end
                    end
                end else if (op_reg == OP_PUT) begin
                    for (int i = 0; i < N; i++) begin
                        if (free_idx_reg == IW'(i)) begin
                            valid_reg[i] <= 1'b1;
                            age_reg[i]   <= '0;
                        end else if (keep_v[i]) begin
                            valid_reg[i] <= 1'b1;
                            age_reg[i]   <= age_reg[i] + AW'(1);
                        end else begin
                            valid_reg[i] <= 1'b0;
                            age_reg[i]   <= '0;
                        end
                    end
                    if (!evict_reg) begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= in_cmd;
            op_key_reg  <= in_key;
            op_data_reg <= in_data;
        end
        if (cmd.match) begin
            hit_reg      <= hit_c;
            hit_idx_reg  <= hit_idx_c;
            evict_reg    <= evict_c;
            lru_idx_reg  <= lru_idx_c;
            free_idx_reg <= free_idx_c;
        end
        if (cmd.commit) begin
            found_reg <= hit_reg;
            rdata_reg <= (hit_reg && (op_reg == OP_GET)) ? val_reg[hit_idx_reg] : MISS_DATA;
            ev_reg    <= evict_reg;
            evk_reg   <= evict_reg ? key_reg[lru_idx_reg] : '0;
            if (op_reg == OP_PUT) begin
                if (hit_reg) begin
                    val_reg[hit_idx_reg] <= op_data_reg;
                end else begin
                    key_reg[free_idx_reg] <= op_key_reg;
                    val_reg[free_idx_reg] <= op_data_reg;
                end
            end
        end
    end

    assign out_found       = found_reg;
    assign out_read_data   = rdata_reg;
    assign out_evicted     = ev_reg;
    assign out_evicted_key = evk_reg;

endmodule

`default_nettype wire

// ===== hdl/lkvc_checker.sv =====
`default_nettype none

module lkvc_checker
    import lkvc_pkg::*;
(
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic                     m_found,
    input wire logic signed [DATA_W-1:0] m_read_data,
    input wire logic                     m_evicted,
    input wire logic signed [DATA_W-1:0] m_evicted_key
);

    // eviction only happens on a put miss
    a_evict_not_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_evicted) |-> !m_found)
        else $error("eviction reported together with a hit");

    a_evict_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_evicted) |-> (m_evicted_key == '0))
        else $error("evicted key nonzero without eviction");

    a_miss_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_read_data == MISS_DATA))
        else $error("miss did not return all ones");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_data)
                                   && $stable(m_evicted_key)))
        else $error("stalled result changed");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_found       (m_found),
    .m_read_data   (m_read_data),
    .m_evicted     (m_evicted),
    .m_evicted_key (m_evicted_key)
);

`default_nettype wire
